@@ hw/rtl/pmfp_pkg.sv @@
package pmfp_pkg;

    localparam logic [7:0] HEADER_BYTE = 8'hAA;

    // Frame byte positions; zero means hunting for the header.
    localparam logic [3:0] POS_HUNT     = 4'd0;
    localparam logic [3:0] POS_CMD      = 4'd1;
    localparam logic [3:0] POS_PM25_LO  = 4'd2;
    localparam logic [3:0] POS_PM25_HI  = 4'd3;
    localparam logic [3:0] POS_PM10_LO  = 4'd4;
    localparam logic [3:0] POS_PM10_HI  = 4'd5;
    localparam logic [3:0] POS_SUM_LAST = 4'd7;
    localparam logic [3:0] POS_CHECK    = 4'd8;
    localparam logic [3:0] POS_TAIL     = 4'd9;

    typedef struct packed {
        logic [15:0] pm25_tenths;
        logic [15:0] pm10_tenths;
        logic        checksum_good;
        logic [15:0] frames_seen;
        logic [15:0] bad_frames;
    } pmfp_result_t;

endpackage

@@ hw/rtl/pmfp_in_stage.sv @@
module pmfp_in_stage (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       byte_valid,
    output logic [7:0] byte_data,
    input  logic       byte_take
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;

    // Slot frees up in the same cycle the core consumes it.
    assign s_ready    = !valid_reg || byte_take;
    assign valid_next = (s_valid && s_ready) ? 1'b1 : (byte_take ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_rx_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

endmodule

@@ hw/rtl/pmfp_frame_core.sv @@
module pmfp_frame_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  byte_valid,
    input  logic [7:0]            byte_data,
    output logic                  byte_take,
    input  logic                  out_free,
    output logic                  res_load,
    output pmfp_pkg::pmfp_result_t res_data
);

    logic [3:0]  pos_reg;
    logic [3:0]  pos_next;
    logic [7:0]  sum_reg;
    logic [7:0]  sum_next;
    logic [15:0] cap25_reg;
    logic [15:0] cap25_next;
    logic [15:0] cap10_reg;
    logic [15:0] cap10_next;
    logic [15:0] held25_reg;
    logic [15:0] held25_next;
    logic [15:0] held10_reg;
    logic [15:0] held10_next;
    logic [15:0] frames_reg;
    logic [15:0] frames_next;
    logic [15:0] errors_reg;
    logic [15:0] errors_next;
    logic        ok_reg;
    logic        ok_next;
    logic        is_tail;
    logic        match;

    assign is_tail   = (pos_reg == pmfp_pkg::POS_TAIL);
    assign byte_take = byte_valid && (!is_tail || out_free);
    assign res_load  = byte_valid && is_tail && out_free;
    assign match     = (byte_data == sum_reg);

    always_comb begin
        pos_next    = pos_reg;
        sum_next    = sum_reg;
        cap25_next  = cap25_reg;
        cap10_next  = cap10_reg;
        held25_next = held25_reg;
        held10_next = held10_reg;
        frames_next = frames_reg;
        errors_next = errors_reg;
        ok_next     = ok_reg;
        if (!(pos_reg inside {[pmfp_pkg::POS_CMD:pmfp_pkg::POS_TAIL]})) begin
            pos_next = (byte_data == pmfp_pkg::HEADER_BYTE) ? pmfp_pkg::POS_CMD
                                                            : pmfp_pkg::POS_HUNT;
        end else begin
            pos_next = is_tail ? pmfp_pkg::POS_HUNT : pos_reg + 4'd1;
            case (pos_reg)
                pmfp_pkg::POS_CMD:     sum_next = 8'd0;
                pmfp_pkg::POS_PM25_LO: cap25_next = {cap25_reg[15:8], byte_data};
                pmfp_pkg::POS_PM25_HI: cap25_next = {byte_data, cap25_reg[7:0]};
                pmfp_pkg::POS_PM10_LO: cap10_next = {cap10_reg[15:8], byte_data};
                pmfp_pkg::POS_PM10_HI: cap10_next = {byte_data, cap10_reg[7:0]};
                default: ;
            endcase
            if (pos_reg inside {[pmfp_pkg::POS_PM25_LO:pmfp_pkg::POS_SUM_LAST]}) begin
                sum_next = sum_reg + byte_data;
            end
            if (pos_reg == pmfp_pkg::POS_CHECK) begin
                ok_next     = match;
                frames_next = frames_reg + 16'd1;
                if (match) begin
                    held25_next = cap25_reg;
                    held10_next = cap10_reg;
                end else begin
                    errors_next = errors_reg + 16'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= pmfp_pkg::POS_HUNT;
            sum_reg    <= 8'd0;
            cap25_reg  <= 16'd0;
            cap10_reg  <= 16'd0;
            held25_reg <= 16'd0;
            held10_reg <= 16'd0;
            frames_reg <= 16'd0;
            errors_reg <= 16'd0;
            ok_reg     <= 1'b0;
        end else if (byte_take) begin
            pos_reg    <= pos_next;
            sum_reg    <= sum_next;
            cap25_reg  <= cap25_next;
            cap10_reg  <= cap10_next;
            held25_reg <= held25_next;
            held10_reg <= held10_next;
            frames_reg <= frames_next;
            errors_reg <= errors_next;
            ok_reg     <= ok_next;
        end
    end

    // Everything was settled at the checksum byte; the tail just reports it.
    assign res_data.pm25_tenths   = held25_reg;
    assign res_data.pm10_tenths   = held10_reg;
    assign res_data.checksum_good = ok_reg;
    assign res_data.frames_seen   = frames_reg;
    assign res_data.bad_frames    = errors_reg;

endmodule

@@ hw/rtl/pmfp_out_stage.sv @@
module pmfp_out_stage (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   res_load,
    input  pmfp_pkg::pmfp_result_t res_data,
    output logic                   out_free,
    output logic                   m_valid,
    input  logic                   m_ready,
    output pmfp_pkg::pmfp_result_t m_data
);

    logic                   valid_reg;
    logic                   valid_next;
    pmfp_pkg::pmfp_result_t data_reg;

    assign out_free   = !valid_reg || m_ready;
    assign valid_next = res_load ? 1'b1 : (m_ready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            data_reg <= res_data;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

@@ hw/rtl/pm_sensor_frame_parser_unit.sv @@
// Particulate sensor frame parser. Takes one received serial byte per
// transaction on s_ and hunts for the 0xAA header, then collects a command
// byte, six payload bytes, a checksum and a tail. The checksum is the payload
// sum modulo 256; on a match the little-endian PM2.5 and PM10 words are held,
// otherwise the old values stay and the bad-frame count rises. The tail byte
// of each frame produces one m_ transaction carrying the held values, the
// checksum flag and both wrapping 16-bit counts; no other byte produces one.
// Throughput is one byte per clock unless a tail byte stalls: the byte
// sits in an input register, the frame state register updates when the core
// takes it, and the result lands in an output register that drives m_valid.
// Only a tail byte that meets a full, unread output register stalls the
// input; all other bytes keep flowing while a result waits.
module pm_sensor_frame_parser_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // byte input
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    // result output
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_pm25_tenths,
    output logic [15:0] m_pm10_tenths,
    output logic        m_checksum_good,
    output logic [15:0] m_frames_seen,
    output logic [15:0] m_bad_frames
);

    logic                   byte_valid;
    logic [7:0]             byte_data;
    logic                   byte_take;
    logic                   out_free;
    logic                   res_load;
    pmfp_pkg::pmfp_result_t res_data;
    pmfp_pkg::pmfp_result_t m_data;

    // Input register.
    pmfp_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .byte_take  (byte_take)
    );

    // Frame state and checksum.
    pmfp_frame_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .byte_take  (byte_take),
        .out_free   (out_free),
        .res_load   (res_load),
        .res_data   (res_data)
    );

    // Result register.
    pmfp_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .res_load (res_load),
        .res_data (res_data),
        .out_free (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    assign m_pm25_tenths   = m_data.pm25_tenths;
    assign m_pm10_tenths   = m_data.pm10_tenths;
    assign m_checksum_good = m_data.checksum_good;
    assign m_frames_seen   = m_data.frames_seen;
    assign m_bad_frames    = m_data.bad_frames;

endmodule

@@ hw/rtl/pmfp_checker.sv @@
module pmfp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_pm25_tenths,
    input logic [15:0] m_pm10_tenths,
    input logic        m_checksum_good,
    input logic [15:0] m_frames_seen,
    input logic [15:0] m_bad_frames
);

    logic [15:0] last_frames_reg;
    logic [15:0] last_bad_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_frames_reg <= 16'd0;
            last_bad_reg    <= 16'd0;
        end else if (m_valid && m_ready) begin
            last_frames_reg <= m_frames_seen;
            last_bad_reg    <= m_bad_frames;
        end
    end

    // Each result is exactly one frame past the previous one.
    a_frame_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_frames_seen == last_frames_reg + 16'd1)
        else $error("frames_seen skipped or repeated");

    // Bad count rises only with a failed checksum.
    a_bad_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_bad_frames == last_bad_reg + {15'd0, !m_checksum_good})
        else $error("bad_frames inconsistent with checksum flag");

    // Nothing to report right after reset.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pm25_tenths)
            && $stable(m_pm10_tenths) && $stable(m_frames_seen))
        else $error("stalled result changed");

endmodule

bind pm_sensor_frame_parser_unit pmfp_checker u_pmfp_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_pm25_tenths   (m_pm25_tenths),
    .m_pm10_tenths   (m_pm10_tenths),
    .m_checksum_good (m_checksum_good),
    .m_frames_seen   (m_frames_seen),
    .m_bad_frames    (m_bad_frames)
);

@@ tb/pm_sensor_frame_parser_unit_test.sv @@
module pm_sensor_frame_parser_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS   = 800;
    localparam int WATCHDOG_LIMIT = 2000;
    // slack after the last result has come back, before the run ends
    localparam int SETTLE_CYCLES  = 10;

    localparam pmfp_pkg::pmfp_result_t NO_READING = '0;
    // all-0xFF payload, good checksum: held words at full scale, first frame
    localparam pmfp_pkg::pmfp_result_t FULL_SCALE =
        {16'hFFFF, 16'hFFFF, 1'b1, 16'd1, 16'd0};
    // bad checksum: held words stay, error count rises, flag low
    localparam pmfp_pkg::pmfp_result_t KEPT_AFTER_BAD =
        {16'hFFFF, 16'hFFFF, 1'b0, 16'd2, 16'd1};

    typedef struct packed {
        logic [7:0]             rx;
        logic                   pinned;
        pmfp_pkg::pmfp_result_t res;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_pm25_tenths;
    logic [15:0] m_pm10_tenths;
    logic        m_checksum_good;
    logic [15:0] m_frames_seen;
    logic [15:0] m_bad_frames;

    // Typed-in expectation travels with the byte, held like the payload.
    logic                   row_pinned = 1'b0;
    pmfp_pkg::pmfp_result_t row_res = '0;

    // Frame state mirrored from the parser's behavior.
    logic [3:0]  frame_pos = pmfp_pkg::POS_HUNT;
    logic [7:0]  payload_sum = '0;
    logic [15:0] pm25_cap = '0;
    logic [15:0] pm10_cap = '0;
    logic [15:0] pm25_held = '0;
    logic [15:0] pm10_held = '0;
    logic [15:0] frames_total = '0;
    logic [15:0] bad_total = '0;
    logic        sum_match = 1'b0;

    pmfp_pkg::pmfp_result_t pending_readings [$];
    int  mismatches = 0;
    int  stuck_cycles = 0;
    int  frame_items = 0;
    bit  steady = 1'b0;     // last part of the run: no idling on either side
    bit  tx_calm = 1'b0;
    bit  rx_calm = 1'b0;

    // Directed table: leading noise while hunting, a full-scale frame, then
    // a frame with 0xAA as command and payload data and a wrong checksum,
    // closed by a zero tail byte.
    dir_row_t dir_rows [22] = '{
        {8'h55, 1'b0, NO_READING}, {8'h00, 1'b0, NO_READING},
        {8'hAA, 1'b0, NO_READING}, {8'hC0, 1'b0, NO_READING},
        {8'hFF, 1'b0, NO_READING}, {8'hFF, 1'b0, NO_READING},
        {8'hFF, 1'b0, NO_READING}, {8'hFF, 1'b0, NO_READING},
        {8'hFF, 1'b0, NO_READING}, {8'hFF, 1'b0, NO_READING},
        {8'hFA, 1'b0, NO_READING}, {8'hAB, 1'b1, FULL_SCALE},
        {8'hAA, 1'b0, NO_READING}, {8'hAA, 1'b0, NO_READING},
        {8'hAA, 1'b0, NO_READING}, {8'h00, 1'b0, NO_READING},
        {8'h00, 1'b0, NO_READING}, {8'h00, 1'b0, NO_READING},
        {8'h00, 1'b0, NO_READING}, {8'h00, 1'b0, NO_READING},
        {8'h01, 1'b0, NO_READING}, {8'h00, 1'b1, KEPT_AFTER_BAD}
    };

    pm_sensor_frame_parser_unit i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pm25_tenths   (m_pm25_tenths),
        .m_pm10_tenths   (m_pm10_tenths),
        .m_checksum_good (m_checksum_good),
        .m_frames_seen   (m_frames_seen),
        .m_bad_frames    (m_bad_frames)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Advance the frame state by one received byte; done is set on the tail.
    task automatic parse_byte(input logic [7:0] rx, output bit done,
                              output pmfp_pkg::pmfp_result_t res);
        done = 1'b0;
        res = '0;
        if (!(frame_pos inside {[pmfp_pkg::POS_CMD:pmfp_pkg::POS_TAIL]})) begin
            // positions past the tail behave like hunting
            frame_pos = (rx == pmfp_pkg::HEADER_BYTE) ? pmfp_pkg::POS_CMD
                                                      : pmfp_pkg::POS_HUNT;
        end else begin
            case (frame_pos)
                pmfp_pkg::POS_CMD:     payload_sum = '0;
                pmfp_pkg::POS_PM25_LO: pm25_cap[7:0] = rx;
                pmfp_pkg::POS_PM25_HI: pm25_cap[15:8] = rx;
                pmfp_pkg::POS_PM10_LO: pm10_cap[7:0] = rx;
                pmfp_pkg::POS_PM10_HI: pm10_cap[15:8] = rx;
                default: ;
            endcase
            if (frame_pos inside {[pmfp_pkg::POS_PM25_LO:pmfp_pkg::POS_SUM_LAST]})
                payload_sum = payload_sum + rx;
            if (frame_pos == pmfp_pkg::POS_CHECK) begin
                sum_match = (rx == payload_sum);
                frames_total = frames_total + 16'd1;
                if (sum_match) begin
                    pm25_held = pm25_cap;
                    pm10_held = pm10_cap;
                end else begin
                    bad_total = bad_total + 16'd1;
                end
            end
            if (frame_pos == pmfp_pkg::POS_TAIL) begin
                // tail value is never checked
                done = 1'b1;
                res.pm25_tenths   = pm25_held;
                res.pm10_tenths   = pm10_held;
                res.checksum_good = sum_match;
                res.frames_seen   = frames_total;
                res.bad_frames    = bad_total;
                frame_pos = pmfp_pkg::POS_HUNT;
            end else begin
                frame_pos = frame_pos + 4'd1;
            end
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatches++;
        end
    endtask

    // Scoreboard: predict on each accepted byte, compare each result
    // against the oldest outstanding reading.
    always @(posedge aclk) begin : scoreboard
        bit                     done;
        pmfp_pkg::pmfp_result_t predicted;
        pmfp_pkg::pmfp_result_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                parse_byte(s_rx_byte, done, predicted);
                if (done)
                    pending_readings.push_back(row_pinned ? row_res : predicted);
            end
            if (m_valid && m_ready) begin
                if (pending_readings.size() == 0) begin
                    $error("result transaction with no frame outstanding");
                    mismatches++;
                end else begin
                    want = pending_readings.pop_front();
                    check_field("pm25_tenths", want.pm25_tenths, m_pm25_tenths);
                    check_field("pm10_tenths", want.pm10_tenths, m_pm10_tenths);
                    check_field("checksum_good", 16'(want.checksum_good),
                                16'(m_checksum_good));
                    check_field("frames_seen", want.frames_seen, m_frames_seen);
                    check_field("bad_frames", want.bad_frames, m_bad_frames);
                end
            end
        end
    end

    // Watchdog: too long without any transaction on either side.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= WATCHDOG_LIMIT) begin
                $error("no transaction for %0d cycles", stuck_cycles);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Result side: random stall bursts, with calm stretches in between.
    initial begin
        @(posedge aclk);
        forever begin
            if ($urandom_range(0, 99) == 0)
                rx_calm = !rx_calm;
            if (!steady && !rx_calm && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // One byte transaction; may idle first. Returns at the accepting edge
    // with valid still high.
    task automatic send_byte(input logic [7:0] rx, input bit pinned,
                             input pmfp_pkg::pmfp_result_t res);
        if (!steady && !tx_calm && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_rx_byte  <= rx;
        row_pinned <= pinned;
        row_res    <= res;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Hold off the sender until every outstanding reading has come back.
    task automatic drain_readings();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_readings.size() != 0);
    endtask

    // Header, command, six payload bytes, checksum, tail; only the first
    // keep bytes go out, so a short count leaves a broken frame behind.
    task automatic send_frame(input bit corrupt, input int keep);
        logic [7:0] fb [10];
        logic [7:0] sum;
        sum = '0;
        fb[0] = pmfp_pkg::HEADER_BYTE;
        fb[1] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'hC0;
        for (int i = 2; i < 8; i++) begin
            case ($urandom_range(0, 7))
                0:       fb[i] = 8'h00;
                1:       fb[i] = 8'hFF;
                default: fb[i] = 8'($urandom);
            endcase
            sum = sum + fb[i];
        end
        fb[8] = corrupt ? sum + 8'($urandom_range(1, 255)) : sum;
        fb[9] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'hAB;
        for (int i = 0; i < keep; i++) begin
            send_byte(fb[i], 1'b0, NO_READING);
            frame_items++;
        end
    endtask

    initial begin
        bit drained_once;
        logic [7:0] noise;
        drained_once = 1'b0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i])
            send_byte(dir_rows[i].rx, dir_rows[i].pinned, dir_rows[i].res);
        drain_readings();

        // Mostly well-formed frames with random content; some noise between
        // frames and some frames cut short so the next header lands inside.
        // The last quarter runs at full rate on both sides.
        while (frame_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 3) == 0)
                tx_calm = !tx_calm;
            case ($urandom_range(0, 15))
                0, 1: begin
                    repeat ($urandom_range(1, 4)) begin
                        noise = 8'($urandom);
                        // a stray header now and then, otherwise stay hunting
                        if (noise == pmfp_pkg::HEADER_BYTE && $urandom_range(0, 3) != 0)
                            noise = noise ^ 8'h01;
                        send_byte(noise, 1'b0, NO_READING);
                    end
                end
                2:       send_frame($urandom_range(0, 1) == 1, $urandom_range(2, 9));
                default: send_frame($urandom_range(0, 3) == 0, 10);
            endcase
            if (!drained_once && frame_items >= RANDOM_ITEMS / 2) begin
                drain_readings();
                drained_once = 1'b1;
            end
            if (frame_items >= RANDOM_ITEMS - RANDOM_ITEMS / 4)
                steady = 1'b1;
        end

        drain_readings();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
